[rtl/core/rcd_pkg.sv]
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared widths, defaults and command codes of the row cache directory.
// ----------------------------------------------------------------------------
`default_nettype none

package rcd_pkg;

   localparam int ID_W          = 32;
   localparam int SYNC_W        = 8;
   localparam int IDX_W         = 8;
   localparam int LINES_DEFAULT = 256;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_MATCH = 2'd2,
      CMD_SYNC  = 2'd3
   } cmd_type;

endpackage

`default_nettype wire

[rtl/core/rcd_req_if.sv]
// ----------------------------------------------------------------------------
// rcd_req_if
// Command channel of the row cache directory: valid/ready plus one command.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcd_req_if;
   import rcd_pkg::*;

   logic                valid;
   logic                ready;
   cmd_type             command;
   logic [ID_W-1:0]     row_id;
   logic [SYNC_W-1:0]   sync_line;
   logic                backing_ok;

   modport source (output valid, command, row_id, sync_line, backing_ok, input ready);
   modport sink   (input valid, command, row_id, sync_line, backing_ok, output ready);
endinterface

`default_nettype wire

[rtl/core/rcd_rsp_if.sv]
// ----------------------------------------------------------------------------
// rcd_rsp_if
// Result channel of the row cache directory: valid/ready plus one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcd_rsp_if;
   import rcd_pkg::*;

   logic                valid;
   logic                ready;
   logic                hit;
   logic [IDX_W-1:0]    line_index;
   logic                fetch;
   logic                writeback;
   logic [ID_W-1:0]     writeback_id;
   logic                store_data;
   logic                status;

   modport source (output valid, hit, line_index, fetch, writeback, writeback_id,
                   store_data, status, input ready);
   modport sink   (input valid, hit, line_index, fetch, writeback, writeback_id,
                   store_data, status, output ready);
endinterface

`default_nettype wire

[rtl/core/rcd_ram.sv]
// ----------------------------------------------------------------------------
// rcd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

[rtl/core/rcd_index_map.sv]
// ----------------------------------------------------------------------------
// rcd_index_map
// Splits an id into line (id mod LINES) and tag (id div LINES). A power of two
// is a registered bit split; any other count multiplies by a constant reciprocal
// and takes back the remainder through product, quotient and remainder registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rcd_index_map #(
   parameter int LINES = rcd_pkg::LINES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [rcd_pkg::ID_W-1:0]             dividend,
   output logic                                 done,
   output logic [$clog2(LINES)-1:0]             line,
   output logic [$clog2(((64'd1 << rcd_pkg::ID_W) - 1) / LINES + 1)-1:0] tag
);
   import rcd_pkg::*;

   localparam int  LINE_W = $clog2(LINES);
   localparam int  TAG_W  = $clog2(((64'd1 << ID_W) - 1) / LINES + 1);
   localparam bit  POW2   = (LINES & (LINES - 1)) == 0;

   generate
      if (POW2) begin : g_split
         logic              done_ff;
         logic [LINE_W-1:0] line_ff;
         logic [TAG_W-1:0]  tag_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               line_ff <= dividend[LINE_W-1:0];
               tag_ff  <= TAG_W'(dividend >> LINE_W);
            end
         end

         assign done = done_ff;
         assign line = line_ff;
         assign tag  = tag_ff;
      end else begin : g_recip
         // floor(n / LINES) == floor(n * RECIP / 2^SHIFT) for every 32-bit n
         // when RECIP = ceil(2^SHIFT / LINES) and SHIFT = ID_W + ceil(log2 LINES)
         localparam int            SHIFT = ID_W + LINE_W;
         localparam int            LO_W  = 17;
         localparam int            HI_W  = ID_W + 1 - LO_W;
         localparam int            PLO_W = ID_W + LO_W;
         localparam int            PHI_W = ID_W + HI_W;
         localparam int            SUM_W = 2 * ID_W + 1;
         localparam logic [ID_W:0] RECIP =
            (ID_W + 1)'(((64'd1 << SHIFT) + 64'(LINES) - 64'd1) / 64'(LINES));

         logic              prod_vld_ff;
         logic              quo_vld_ff;
         logic              done_ff;
         logic [ID_W-1:0]   num_ff;
         logic [PLO_W-1:0]  prod_lo_ff;
         logic [PHI_W-1:0]  prod_hi_ff;
         logic [SUM_W-1:0]  prod_sum;
         logic [TAG_W-1:0]  quo_ff;
         logic [LINE_W-1:0] rem_ff;

         // reciprocal split in two halves so each product stays narrow
         assign prod_sum = SUM_W'(prod_lo_ff) + (SUM_W'(prod_hi_ff) << LO_W);

         always_ff @(posedge clock) begin
            if (reset) begin
               prod_vld_ff <= 1'b0;
               quo_vld_ff  <= 1'b0;
               done_ff     <= 1'b0;
            end else begin
               prod_vld_ff <= start;
               quo_vld_ff  <= prod_vld_ff;
               done_ff     <= quo_vld_ff;
            end
            if (start) begin
               num_ff     <= dividend;
               prod_lo_ff <= PLO_W'(dividend) * PLO_W'(RECIP[LO_W-1:0]);
               prod_hi_ff <= PHI_W'(dividend) * PHI_W'(RECIP[ID_W:LO_W]);
            end
            if (prod_vld_ff) begin
               quo_ff <= TAG_W'(prod_sum >> SHIFT);
            end
            if (quo_vld_ff) begin
               rem_ff <= LINE_W'(num_ff - ID_W'(ID_W'(quo_ff) * ID_W'(LINES)));
            end
         end

         assign done = done_ff;
         assign line = rem_ff;
         assign tag  = quo_ff;
      end
   endgenerate
endmodule

`default_nettype wire

[rtl/core/direct_mapped_row_cache_directory_top.sv]
// Flow: a new command is taken only in idle, after the last has left the update
//   step; non-power-of-two LINES use the longer reciprocal-multiply line split.
// Result: the beat is registered as the update step ends; a result waiting in
//   the output register holds off the next command's update, not its accept.
// Reset: a clearing pass sweeps all LINES entries of the directory RAM; commands are
//   held off until it finishes.
// ----------------------------------------------------------------------------
// direct_mapped_row_cache_directory_top
// Tag/valid/dirty directory of a direct-mapped write-back row cache, kept in
// one RAM with read-modify-write per command.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_row_cache_directory_top #(
   parameter int LINES = rcd_pkg::LINES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   rcd_req_if.sink    req_chan,
   rcd_rsp_if.source  rsp_chan
);
   import rcd_pkg::*;

   localparam int LINE_W  = $clog2(LINES);
   localparam int TAG_W   = $clog2(((64'd1 << ID_W) - 1) / LINES + 1);
   localparam int ENTRY_W = TAG_W + 2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP,
      ST_UPDATE
   } state_type;

   state_type           state_ff, state_in;
   logic [LINE_W-1:0]   clear_cnt_ff, clear_cnt_in;
   cmd_type             cmd_ff;
   logic                ok_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic [IDX_W-1:0]    rsp_line_ff;
   logic                rsp_fetch_ff;
   logic                rsp_wb_ff;
   logic [ID_W-1:0]     rsp_wb_id_ff;
   logic                rsp_store_ff;
   logic                rsp_status_ff;

   logic                req_accept;
   logic                out_free;
   logic                upd_fire;

   logic                map_done;
   logic [LINE_W-1:0]   map_line;
   logic [TAG_W-1:0]    map_tag;

   logic                ram_wr_en;
   logic [LINE_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [ENTRY_W-1:0]  ram_rd_data;

   logic                ent_valid, ent_dirty;
   logic [TAG_W-1:0]    ent_tag;
   logic                upd_hit, upd_fetch, upd_wb, upd_store, upd_fail, upd_write;
   logic [ENTRY_W-1:0]  upd_entry;
   logic [ID_W-1:0]     victim_id;

   assign req_chan.ready = state_ff == ST_IDLE;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign upd_fire       = state_ff == ST_UPDATE && out_free;

   rcd_index_map #(.LINES(LINES)) u_index_map (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .dividend ((req_chan.command == CMD_SYNC) ? ID_W'(req_chan.sync_line)
                                                : req_chan.row_id),
      .done     (map_done),
      .line     (map_line),
      .tag      (map_tag)
   );

   assign ram_rd_en = state_ff == ST_MAP && map_done;

   rcd_ram #(.WIDTH(ENTRY_W), .DEPTH(LINES)) u_dir_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (map_line),
      .rd_data (ram_rd_data)
   );

   // entry layout: {valid, dirty, tag}
   always_comb begin
      ent_valid = ram_rd_data[ENTRY_W-1];
      ent_dirty = ram_rd_data[ENTRY_W-2];
      ent_tag   = ram_rd_data[TAG_W-1:0];
      victim_id = ID_W'(ID_W'(ent_tag) * ID_W'(LINES)) + ID_W'(map_line);

      upd_hit   = 1'b0;
      upd_fetch = 1'b0;
      upd_wb    = 1'b0;
      upd_store = 1'b0;
      upd_fail  = 1'b0;
      upd_write = 1'b0;
      upd_entry = ram_rd_data;

      unique case (cmd_ff)
         CMD_READ, CMD_WRITE: begin
            upd_hit = ent_valid && ent_tag == map_tag;
            if (!upd_hit) begin
               upd_wb    = ent_valid && ent_dirty;
               upd_fetch = cmd_ff == CMD_READ;
               upd_fail  = (upd_wb || upd_fetch) && !ok_ff;
               upd_write = !upd_fail;
               upd_entry = {1'b1, cmd_ff == CMD_WRITE, map_tag};
            end else if (cmd_ff == CMD_WRITE) begin
               upd_write = 1'b1;
               upd_entry = {1'b1, 1'b1, ent_tag};
            end
            upd_store = cmd_ff == CMD_WRITE && !upd_fail;
         end
         CMD_MATCH: begin
            upd_hit = ent_valid && ent_tag == map_tag;
         end
         CMD_SYNC: begin
            if (ent_valid && ent_dirty) begin
               upd_wb    = 1'b1;
               upd_fail  = !ok_ff;
               upd_write = ok_ff;
               upd_entry = {1'b1, 1'b0, ent_tag};
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = map_line;
      ram_wr_data = upd_entry;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_cnt_ff;
         ram_wr_data = '0;
      end else if (upd_fire) begin
         ram_wr_en = upd_write;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + 1'b1;
            if (clear_cnt_ff == LINE_W'(LINES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            if (map_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_accept) begin
         cmd_ff <= req_chan.command;
         ok_ff  <= req_chan.backing_ok;
      end
      if (upd_fire) begin
         rsp_hit_ff    <= upd_hit;
         rsp_line_ff   <= IDX_W'(map_line);
         rsp_fetch_ff  <= upd_fetch;
         rsp_wb_ff     <= upd_wb;
         rsp_wb_id_ff  <= upd_wb ? victim_id : '0;
         rsp_store_ff  <= upd_store;
         rsp_status_ff <= upd_fail;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.hit          = rsp_hit_ff;
   assign rsp_chan.line_index   = rsp_line_ff;
   assign rsp_chan.fetch        = rsp_fetch_ff;
   assign rsp_chan.writeback    = rsp_wb_ff;
   assign rsp_chan.writeback_id = rsp_wb_id_ff;
   assign rsp_chan.store_data   = rsp_store_ff;
   assign rsp_chan.status       = rsp_status_ff;

   a_map_done_in_map: assert property (@(posedge clock) disable iff (reset)
      map_done |-> state_ff == ST_MAP)
      else $error("index map finished outside the map step");

   a_ram_write_window: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_UPDATE))
      else $error("directory written outside clear or update");

   a_update_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      upd_fire |=> rsp_valid_ff)
      else $error("update did not load a result beat");

   a_fetch_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fetch_ff) |-> !rsp_hit_ff)
      else $error("fetch reported on a hit");

   a_wb_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_wb_ff) |-> rsp_wb_id_ff == '0)
      else $error("write-back id set without write-back");
endmodule

`default_nettype wire
